/* hdl/two_class_priority_queue_bank_macros.svh */
// assertion macros shared by the priority queue bank modules
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef TWO_CLASS_PRIORITY_QUEUE_BANK_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_BANK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `TPQ_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)
`define TPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    `TPQ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)
`else
`define TPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/tpq_pkg.sv */
// shared constants, types and codes for the two-class priority queue bank
// no dependencies
package tpq_pkg;

    localparam int NUM_QUEUES = 32;
    localparam int DEPTH      = 8;
    localparam int TAG_WIDTH  = 16;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int QA_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CF_PTR_W       = $clog2(CMD_FIFO_DEPTH);

    // external field widths
    localparam int IN_QIDX_W  = 5;
    localparam int IN_TAG_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int OUT_TAG_W  = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int M_PAD_W    = M_TDATA_W - OUT_TAG_W - 1;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TAKE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TAKEN = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic                 urg;
        logic [TAG_WIDTH-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0]        fill;
        entry_t [DEPTH-1:0]      slot;
    } row_t;

    typedef struct packed {
        logic                 req;
        logic                 in_range;
        logic [QA_W-1:0]      qaddr;
        logic [TAG_WIDTH-1:0] tag;
        logic                 urg;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_TAG_W-1:0] head_tag;
        logic                 head_urgent;
    } res_t;

endpackage

/* hdl/tpq_front.sv */
// request front end: unpacks and classifies input words into commands
// and buffers them in a short command queue; uses tpq_pkg
`include "two_class_priority_queue_bank_macros.svh"

module tpq_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tpq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    output logic                         cmd_valid,
    output tpq_pkg::cmd_t                cmd,
    input  logic                         cmd_pop
);

    tpq_pkg::cmd_t                   fifo_mem [tpq_pkg::CMD_FIFO_DEPTH];
    logic [tpq_pkg::CF_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tpq_pkg::CF_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tpq_pkg::CF_PTR_W:0]      count_reg, count_next;
    tpq_pkg::cmd_t                   in_cmd;
    logic [31:0]                     tag_ext;
    logic [31:0]                     qidx_ext;
    logic                            push;

    // classify the incoming word
    always_comb begin
        tag_ext         = 32'(s_tdata[tpq_pkg::IN_QIDX_W +: tpq_pkg::IN_TAG_W]);
        qidx_ext        = 32'(s_tdata[tpq_pkg::IN_QIDX_W-1:0]);
        in_cmd.req      = s_tuser;
        in_cmd.in_range = (qidx_ext < 32'(tpq_pkg::NUM_QUEUES));
        in_cmd.qaddr    = qidx_ext[tpq_pkg::QA_W-1:0];
        in_cmd.tag      = tag_ext[tpq_pkg::TAG_WIDTH-1:0];
        in_cmd.urg      = s_tdata[tpq_pkg::IN_QIDX_W + tpq_pkg::IN_TAG_W];
    end

    assign s_tready  = (count_reg != (tpq_pkg::CF_PTR_W + 1)'(tpq_pkg::CMD_FIFO_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = fifo_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (cmd_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, cmd_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    `TPQ_ASSERT(a_cnt_bound, aclk, aresetn, count_reg <= (tpq_pkg::CF_PTR_W + 1)'(tpq_pkg::CMD_FIFO_DEPTH), "command queue overfilled")
    `TPQ_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, cmd_pop, count_reg != '0, "pop from empty command queue")
    `TPQ_ASSERT_NXT(a_push_grows, aclk, aresetn, push && !cmd_pop, count_reg == $past(count_reg) + 1'b1, "push lost")

endmodule

/* hdl/tpq_back.sv */
// execution back end: row memory of all queues, read-modify-write of one
// queue row per command, result register; uses tpq_pkg
`include "two_class_priority_queue_bank_macros.svh"

module tpq_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    input  tpq_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output tpq_pkg::res_t out_res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    tpq_pkg::row_t                     mem_row [tpq_pkg::NUM_QUEUES];
    logic [tpq_pkg::NUM_QUEUES-1:0]    valid_reg;
    logic                              state_reg, state_next;
    tpq_pkg::cmd_t                     cmd_reg;
    tpq_pkg::row_t                     row_rd_reg;
    logic                              valid_rd_reg;
    logic                              out_valid_reg, out_valid_next;
    tpq_pkg::res_t                     res_reg, res_next;

    logic [tpq_pkg::CNT_W-1:0]         n;
    logic                              full, empty;
    logic [tpq_pkg::DEPTH-1:0]         keep, prev_keep;
    tpq_pkg::entry_t                   new_entry;
    tpq_pkg::entry_t [tpq_pkg::DEPTH-1:0] shift_up, shift_dn;
    tpq_pkg::row_t                     add_row, pop_row, wr_row;
    logic                              exec_go, wr_en;
    logic [31:0]                       head_ext;

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    // row update: urgent ones form a prefix of the occupied slots
    always_comb begin
        n         = valid_rd_reg ? row_rd_reg.fill : '0;
        full      = (n == tpq_pkg::CNT_W'(tpq_pkg::DEPTH));
        empty     = (n == '0);
        new_entry = '{urg: cmd_reg.urg, tag: cmd_reg.tag};
        for (int i = 0; i < tpq_pkg::DEPTH; i++) begin
            keep[i] = (tpq_pkg::CNT_W'(i) < n) && row_rd_reg.slot[i].urg;
        end
        prev_keep = {keep[tpq_pkg::DEPTH-2:0], 1'b1};
        shift_up  = {row_rd_reg.slot[tpq_pkg::DEPTH-2:0], new_entry};
        shift_dn  = {tpq_pkg::entry_t'('0), row_rd_reg.slot[tpq_pkg::DEPTH-1:1]};

        add_row.fill = n + 1'b1;
        for (int i = 0; i < tpq_pkg::DEPTH; i++) begin
            if (cmd_reg.urg) begin
                if (keep[i]) begin
                    add_row.slot[i] = row_rd_reg.slot[i];
                end else if (prev_keep[i]) begin
                    add_row.slot[i] = new_entry;
                end else begin
                    add_row.slot[i] = shift_up[i];
                end
            end else begin
                add_row.slot[i] = (tpq_pkg::CNT_W'(i) == n) ? new_entry : row_rd_reg.slot[i];
            end
        end

        pop_row.fill = n - 1'b1;
        pop_row.slot = shift_dn;

        wr_row = (cmd_reg.req == tpq_pkg::REQ_ADD) ? add_row : pop_row;
    end

    always_comb begin
        head_ext = 32'(row_rd_reg.slot[0].tag);
        res_next = '0;
        wr_en    = 1'b0;
        if (cmd_reg.req == tpq_pkg::REQ_ADD) begin
            if (!cmd_reg.in_range || full) begin
                res_next.status = tpq_pkg::STAT_FULL;
            end else begin
                res_next.status = tpq_pkg::STAT_ADDED;
                wr_en           = exec_go;
            end
        end else begin
            if (!cmd_reg.in_range || empty) begin
                res_next.status = tpq_pkg::STAT_EMPTY;
            end else begin
                res_next.status      = tpq_pkg::STAT_TAKEN;
                res_next.head_tag    = head_ext[tpq_pkg::OUT_TAG_W-1:0];
                res_next.head_urgent = row_rd_reg.slot[0].urg;
                wr_en                = exec_go;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en) begin
                valid_reg[cmd_reg.qaddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            cmd_reg      <= cmd;
            row_rd_reg   <= mem_row[cmd.qaddr];
            valid_rd_reg <= valid_reg[cmd.qaddr];
        end
        if (wr_en) begin
            mem_row[cmd_reg.qaddr] <= wr_row;
        end
        if (exec_go) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    `TPQ_ASSERT_NXT(a_pop_exec, aclk, aresetn, cmd_pop, state_reg == ST_EXEC, "popped command not executed")
    `TPQ_ASSERT_NXT(a_exec_result, aclk, aresetn, exec_go, out_valid_reg, "executed command gave no result")
    `TPQ_ASSERT_IMP(a_fill_bound, aclk, aresetn, (state_reg == ST_EXEC) && valid_rd_reg, row_rd_reg.fill <= tpq_pkg::CNT_W'(tpq_pkg::DEPTH), "queue fill beyond depth")
    `TPQ_ASSERT_NXT(a_row_valid, aclk, aresetn, wr_en, valid_reg[$past(cmd_reg.qaddr)], "written row not marked valid")

endmodule

/* hdl/two_class_priority_queue_bank.sv */
// channel   dir  tdata (low bit up)                     tuser
// s_        in   queue_index[4:0] entry_tag[20:5]       req_type[0]
//                urgent[21], zero pad to 24
// m_        out  head_tag[15:0] head_urgent[16],        status[1:0]
//                zero pad to 24
//
// in the back end each request first reads its queue row from the row
// memory (registered read), then updates it, writes it back and loads
// the result register
// a 4-word command queue sits between input and back end
// reset clears per-queue valid bits and control state; no memory sweep
// a stalled result holds the back end; input keeps flowing until the
// command queue fills
// top level of the two-class priority queue bank; uses tpq_pkg,
// tpq_front and tpq_back

module two_class_priority_queue_bank (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tpq_pkg::S_TDATA_W-1:0] s_tdata,   // queue_index, entry_tag, urgent
    input  logic                          s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tpq_pkg::M_TDATA_W-1:0] m_tdata,   // head_tag, head_urgent
    output logic [tpq_pkg::STATUS_W-1:0]  m_tuser    // status
);

    logic          cmd_valid;
    logic          cmd_pop;
    tpq_pkg::cmd_t cmd;
    tpq_pkg::res_t res;

    tpq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tpq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {{tpq_pkg::M_PAD_W{1'b0}}, res.head_urgent, res.head_tag};
    assign m_tuser = res.status;

endmodule

/* tb/tb_two_class_priority_queue_bank.sv */
// self-checking testbench for the two-class priority queue bank: directed and random
// add/take traffic, checked against a behavioral model of every queue in the bank
// depends on tpq_pkg and two_class_priority_queue_bank
module tb_two_class_priority_queue_bank;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tpq_pkg::S_TDATA_W-1:0] s_tdata = '0;   // queue_index, entry_tag, urgent
    logic                          s_tuser = 1'b0; // req_type
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tpq_pkg::M_TDATA_W-1:0] m_tdata;        // head_tag, head_urgent
    logic [tpq_pkg::STATUS_W-1:0]  m_tuser;        // status

    two_class_priority_queue_bank dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // shadow copy of every queue row
    tpq_pkg::entry_t queue_slots [tpq_pkg::NUM_QUEUES][tpq_pkg::DEPTH];
    int unsigned     queue_count [tpq_pkg::NUM_QUEUES];
    tpq_pkg::res_t   pending_status[$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    bit  sender_gaps = 1'b1;
    bit  receiver_free = 1'b0;
    bit  hold_pending = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic tpq_pkg::res_t apply_request(logic req, logic [4:0] qi,
                                                    logic [15:0] tag, logic urg);
        tpq_pkg::res_t   r;
        int unsigned     n;
        int unsigned     pos;
        tpq_pkg::entry_t e;
        r = '0;
        if (req == tpq_pkg::REQ_ADD) begin
            if (qi >= tpq_pkg::NUM_QUEUES || queue_count[qi] >= tpq_pkg::DEPTH) begin
                r.status = tpq_pkg::STAT_FULL;
            end else begin
                n = queue_count[qi];
                pos = n;
                if (urg) begin
                    // urgent words go right behind the last urgent one
                    pos = 0;
                    for (int i = n; i > 0; i--) begin
                        if (queue_slots[qi][i-1].urg) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = n; i > pos; i--)
                        queue_slots[qi][i] = queue_slots[qi][i-1];
                end
                e.tag = tag[tpq_pkg::TAG_WIDTH-1:0];
                e.urg = urg;
                queue_slots[qi][pos] = e;
                queue_count[qi] = n + 1;
                r.status = tpq_pkg::STAT_ADDED;
            end
        end else if (qi >= tpq_pkg::NUM_QUEUES || queue_count[qi] == 0) begin
            r.status = tpq_pkg::STAT_EMPTY;
        end else begin
            n = queue_count[qi];
            r.status = tpq_pkg::STAT_TAKEN;
            r.head_tag = queue_slots[qi][0].tag;
            r.head_urgent = queue_slots[qi][0].urg;
            for (int i = 0; i + 1 < n; i++)
                queue_slots[qi][i] = queue_slots[qi][i+1];
            queue_slots[qi][n-1] = '0;
            queue_count[qi] = n - 1;
        end
        return r;
    endfunction

    task automatic send_word(logic req, logic [4:0] qi, logic [15:0] tag, logic urg);
        int gap;
        if (sender_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {2'b00, urg, tag, qi};
        do @(posedge aclk); while (!s_tready);
        pending_status.push_back(apply_request(req, qi, tag, urg));
    endtask

    // receiver: alternating ready/stall runs, free-running, or one long hold-off
    initial begin : rx_pattern
        int run_left;
        int hold_left;
        bit stalled;
        run_left = 0;
        hold_left = 0;
        stalled = 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (receiver_free) begin
                m_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    stalled = !stalled;
                    run_left = stalled ? $urandom_range(1, 6) : $urandom_range(1, 20);
                end
                run_left--;
                m_tready <= !stalled;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        tpq_pkg::res_t got;
        tpq_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.head_tag = m_tdata[15:0];
            got.head_urgent = m_tdata[16];
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d tag %h urgent %b",
                             got.status, got.head_tag, got.head_urgent);
            end else begin
                want = pending_status.pop_front();
                if (got.status !== want.status || got.head_tag !== want.head_tag ||
                    got.head_urgent !== want.head_urgent) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d tag %h urgent %b, got %0d %h %b",
                                 want.status, want.head_tag, want.head_urgent,
                                 got.status, got.head_tag, got.head_urgent);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_empty_takes();
        send_word(tpq_pkg::REQ_TAKE, 5'd0, 16'hFFFF, 1'b1);
        send_word(tpq_pkg::REQ_TAKE, 5'd31, 16'h0000, 1'b0);
    endtask

    task automatic test_regular_extremes();
        send_word(tpq_pkg::REQ_ADD, 5'd31, 16'hFFFF, 1'b0);
        send_word(tpq_pkg::REQ_TAKE, 5'd31, 16'h0000, 1'b0);
    endtask

    // mixed classes into one queue until full, two refused adds, then drain past empty
    task automatic test_fill_and_drain();
        logic [15:0] tags [8] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001,
                                  16'h7FFE, 16'h0001, 16'hA5A5, 16'h5A5A};
        logic        urgs [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        for (int i = 0; i < 8; i++)
            send_word(tpq_pkg::REQ_ADD, 5'd0, tags[i], urgs[i]);
        send_word(tpq_pkg::REQ_ADD, 5'd0, 16'hBEEF, 1'b1);
        send_word(tpq_pkg::REQ_ADD, 5'd0, 16'hCAFE, 1'b0);
        for (int i = 0; i < 9; i++)
            send_word(tpq_pkg::REQ_TAKE, 5'd0, 16'($urandom), 1'($urandom));
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_input_backpressure();
        sender_gaps = 1'b0;
        hold_pending = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word(1'($urandom_range(0, 1)), 5'($urandom_range(8, 11)),
                      16'($urandom), 1'($urandom));
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_traffic(int count);
        int          add_pct;
        logic [4:0]  hot [3];
        logic [4:0]  qi;
        logic        req;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) begin
                // alternate fill-heavy and drain-heavy phases on a few hot queues
                add_pct = ((i / 60) % 2 == 0) ? 75 : 25;
                foreach (hot[k])
                    hot[k] = 5'($urandom_range(0, 31));
                sender_gaps = ($urandom_range(0, 3) != 0);
                receiver_free = ($urandom_range(0, 4) == 0);
            end
            qi = ($urandom_range(0, 99) < 75) ? hot[$urandom_range(0, 2)]
                                              : 5'($urandom_range(0, 31));
            req = ($urandom_range(0, 99) < add_pct) ? tpq_pkg::REQ_ADD : tpq_pkg::REQ_TAKE;
            send_word(req, qi, 16'($urandom), 1'($urandom));
        end
        receiver_free = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_takes();
        test_regular_extremes();
        test_fill_and_drain();
        test_input_backpressure();
        test_random_traffic(900);
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/tpq_pkg.sv
hdl/tpq_front.sv
hdl/tpq_back.sv
hdl/two_class_priority_queue_bank.sv
tb/tb_two_class_priority_queue_bank.sv
